// ----- rtl/core/fpcvt_pkg.sv -----
// Package for the fp32 format converter: format codes and field constants.
// Used by the conversion datapath, the top level and the checker.
package fpcvt_pkg;

  localparam int unsigned ElemWidth = 32;
  localparam int unsigned CfgWidth  = 3;

  typedef enum logic [2:0] {
    SRC_HALF   = 3'd0,
    SRC_BF16   = 3'd1,
    SRC_INT8   = 3'd2,
    SRC_SINGLE = 3'd3,
    SRC_NONE   = 3'd4
  } src_fmt_t;

  typedef enum logic [0:0] {
    TGT_SINGLE = 1'b0,
    TGT_OTHER  = 1'b1
  } tgt_fmt_t;

  typedef enum logic [0:0] {
    REG_SOURCE = 1'b0,
    REG_TARGET = 1'b1
  } reg_index_t;

  localparam logic [4:0] HalfExpMax = 5'h1F;
  localparam logic [7:0] ExpBias    = 8'd127;
  localparam logic [7:0] HalfBias   = 8'd15;

  // Position of the top set bit of a 10-bit value (value nonzero).
  function automatic logic [3:0] top_bit10(input logic [9:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/fpcvt_datapath.sv -----
// Combinational conversion of one raw element to a single-precision pattern.
// Depends on fpcvt_pkg.
module fpcvt_datapath (
  input  logic [fpcvt_pkg::ElemWidth-1:0] raw_element,
  input  logic [2:0]                      source_format,
  input  logic                            target_format,
  output logic [fpcvt_pkg::ElemWidth-1:0] single_bits,
  output logic                            unsupported
);
  import fpcvt_pkg::*;

  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_sig;
  logic [3:0]  h_top;
  logic [31:0] half_bits;
  logic [7:0]  i_mag;
  logic [9:0]  i_mag10;
  logic [3:0]  i_top;
  logic [31:0] int_bits;
  logic [22:0] i_frac;
  logic [22:0] h_frac;

  // Half precision: split fields and renormalize subnormals.
  assign h_sign = raw_element[15];
  assign h_exp  = raw_element[14:10];
  assign h_sig  = raw_element[9:0];
  assign h_top  = top_bit10(h_sig);
  assign h_frac = 23'({h_sig, 13'd0} << (5'd10 - {1'b0, h_top}));

  always_comb begin
    if (h_exp == 5'd0) begin
      if (h_sig == 10'd0) begin
        half_bits = {h_sign, 31'd0};
      end else begin
        // Subnormal: exponent is 127 - 24 + top bit position.
        half_bits = {h_sign, 8'(8'd103 + {4'd0, h_top}), h_frac};
      end
    end else if (h_exp == HalfExpMax) begin
      half_bits = {h_sign, 8'hFF, h_sig, 13'd0};
    end else begin
      half_bits = {h_sign, 8'({3'd0, h_exp} - HalfBias + ExpBias), h_sig, 13'd0};
    end
  end

  // Signed int8: magnitude, then normalize.
  assign i_mag   = raw_element[7] ? 8'(~raw_element[7:0] + 8'd1) : raw_element[7:0];
  assign i_mag10 = {2'd0, i_mag};
  assign i_top   = top_bit10(i_mag10);
  assign i_frac  = 23'({i_mag10, 23'd0} >> i_top);

  always_comb begin
    if (raw_element[7:0] == 8'd0) begin
      int_bits = 32'd0;
    end else begin
      int_bits = {raw_element[7], 8'(ExpBias + {4'd0, i_top}), i_frac};
    end
  end

  // Format select.
  always_comb begin
    single_bits = '0;
    unsupported = 1'b0;
    if (target_format != TGT_SINGLE) begin
      unsupported = 1'b1;
    end else begin
      case (source_format)
        SRC_HALF:   single_bits = half_bits;
        SRC_BF16:   single_bits = {raw_element[15:0], 16'd0};
        SRC_INT8:   single_bits = int_bits;
        SRC_SINGLE: single_bits = raw_element;
        default:    unsupported = 1'b1;
      endcase
    end
  end

endmodule

// ----- rtl/core/to_fp32_format_converter_unit.sv -----
// Top level of the fp32 format converter: config registers, input and result registers.
// Depends on fpcvt_pkg and fpcvt_datapath.
// A result strobes on done after passing the input register and the result register.
// Throughput: one element per cycle; busy is never raised, the datapath is a single pass.
// Reset: synchronous rst clears the format registers to half/single and the valid bits.
module to_fp32_format_converter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [fpcvt_pkg::ElemWidth-1:0] raw_element,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [fpcvt_pkg::CfgWidth-1:0]  cfg_data,
  output logic                            done,
  output logic [fpcvt_pkg::ElemWidth-1:0] single_bits,
  output logic                            unsupported
);
  import fpcvt_pkg::*;

  logic [2:0]           source_format;
  logic                 target_format;
  logic                 in_valid;
  logic [ElemWidth-1:0] in_elem;
  logic [ElemWidth-1:0] conv_bits;
  logic                 conv_bad;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= SRC_HALF;
      target_format <= TGT_SINGLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE: source_format <= cfg_data;
        REG_TARGET: target_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_elem <= raw_element;
    end
  end

  fpcvt_datapath u_dp (
    .raw_element  (in_elem),
    .source_format(source_format),
    .target_format(target_format),
    .single_bits  (conv_bits),
    .unsupported  (conv_bad)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      single_bits <= conv_bits;
      unsupported <= conv_bad;
    end
  end

endmodule

// ----- rtl/core/fpcvt_checker.sv -----
// Port-level checker for the fp32 format converter, bound to the top level.
// Depends on fpcvt_pkg for widths.
module fpcvt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [fpcvt_pkg::ElemWidth-1:0] single_bits,
  input logic                            unsupported
);
  import fpcvt_pkg::*;

  // Each accepted beat yields a result after the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("missing result beat");

  // No result beat without a matching earlier accepted beat.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("spurious result beat");

  // An unsupported result carries zero bits.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && unsupported) |-> (single_bits == '0))
    else $error("unsupported result not zero");

  // The unit never stalls.
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

bind to_fp32_format_converter_unit fpcvt_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .single_bits(single_bits), .unsupported(unsupported)
);

// ----- verif/tb.sv -----
// Testbench for the fp32 format converter: directed and random elements under every format setting.
// Depends on fpcvt_pkg and the to_fp32_format_converter_unit RTL.
`timescale 1ns / 1ps

module tb;
  import fpcvt_pkg::*;

  // Expected result of one converted element.
  typedef struct packed {
    logic [31:0] single_bits;
    logic        unsupported;
  } conv_result_t;

  // Scoreboard: predicts each conversion and checks results in order.
  class conv_scoreboard;
    logic [2:0]   src_fmt;
    logic         tgt_fmt;
    conv_result_t pending[$];
    int           errors;

    function new();
      src_fmt = SRC_HALF;
      tgt_fmt = TGT_SINGLE;
      errors  = 0;
    endfunction

    // Exact single pattern of sign and magnitude m (nonzero) times 2^scale.
    function logic [31:0] pack_scaled(logic s, logic [15:0] m, int scale);
      int p;
      logic [31:0] frac;
      logic [7:0]  ex;
      p = 0;
      for (int i = 0; i < 16; i++) begin
        if (m[i]) p = i;
      end
      frac = ({16'd0, m} << (23 - p)) & 32'h007F_FFFF;
      ex   = 8'(127 + scale + p);
      return {s, ex, frac[22:0]};
    endfunction

    function logic [31:0] half_bits(logic [15:0] h);
      logic [4:0] hexp;
      logic [9:0] hsig;
      hexp = h[14:10];
      hsig = h[9:0];
      if (hexp == 5'd0) begin
        if (hsig == 10'd0) return {h[15], 31'd0};
        return pack_scaled(h[15], {6'd0, hsig}, -24);
      end
      if (hexp == 5'h1F) return {h[15], 8'hFF, hsig, 13'd0};
      return {h[15], 8'(hexp + 8'd112), hsig, 13'd0};
    endfunction

    function void note_config(logic idx, logic [2:0] data);
      if (idx == REG_SOURCE) src_fmt = data;
      else tgt_fmt = data[0];
    endfunction

    // Note an accepted element and queue its expected result.
    function void note_element(logic [31:0] raw);
      conv_result_t r;
      r = '0;
      if (tgt_fmt != TGT_SINGLE) r.unsupported = 1'b1;
      else begin
        case (src_fmt)
          SRC_HALF: r.single_bits = half_bits(raw[15:0]);
          SRC_BF16: r.single_bits = {raw[15:0], 16'd0};
          SRC_INT8: begin
            if (raw[7:0] == 8'd0) r.single_bits = '0;
            else if (raw[7]) r.single_bits = pack_scaled(1'b1, 16'(9'd256 - raw[7:0]), 0);
            else r.single_bits = pack_scaled(1'b0, {8'd0, raw[7:0]}, 0);
          end
          SRC_SINGLE: r.single_bits = raw;
          default: r.unsupported = 1'b1;
        endcase
      end
      pending.push_back(r);
    endfunction

    // Check one strobed result against the oldest expectation.
    function void check_result(logic [31:0] bits, logic bad);
      conv_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result bits=%h unsupported=%b", $time, bits, bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (bits !== e.single_bits) begin
        $display("%0t: single_bits expected %h actual %h", $time, e.single_bits, bits);
        errors++;
      end
      if (bad !== e.unsupported) begin
        $display("%0t: unsupported expected %b actual %b", $time, e.unsupported, bad);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] raw_element = '0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;
  logic        done;
  logic [31:0] single_bits;
  logic        unsupported;
  longint      cycles = 0;

  conv_scoreboard sb = new();

  to_fp32_format_converter_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .raw_element(raw_element),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .single_bits(single_bits), .unsupported(unsupported)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(single_bits, unsupported);
    if (cycles > 200000) begin
      $display("** to_fp32_format_converter_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [2:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.note_config(idx, data);
  endtask

  // Send one element beat, with an optional random gap first.
  task automatic send_beat(logic [31:0] raw, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    raw_element <= raw;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_element(raw);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random element biased toward the interesting half and int8 codes.
  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[14:10] = 5'd0;
      1: v[14:10] = 5'h1F;
      2: v[7:0] = 8'h80;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] dir[$];
    dir = '{32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0001, 32'h0000_83FF,
            32'h0000_0400, 32'h0000_7BFF, 32'hABCD_FC00, 32'h0000_7C01, 32'h0000_7E00,
            32'h0000_FFFF, 32'h0000_007F, 32'h0000_0080, 32'h0000_00FF, 32'h1234_5601,
            32'h8000_0000, 32'h7F80_0000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every element under every format.
    for (int f = 0; f < 8; f++) begin
      write_reg(REG_SOURCE, 3'(f));
      foreach (dir[i]) send_beat(dir[i], 1'b0);
      drain();
    end
    write_reg(REG_TARGET, TGT_OTHER);
    write_reg(REG_SOURCE, SRC_HALF);
    foreach (dir[i]) send_beat(dir[i], 1'b0);
    drain();

    // Random phases, each under a random setting.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_SOURCE, ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
                                                       : 3'($urandom_range(4, 7)));
      write_reg(REG_TARGET, ($urandom_range(0, 5) == 0) ? TGT_OTHER : TGT_SINGLE);
      for (int i = 0; i < 75; i++) send_beat(rand_elem(), (ph % 3) != 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** to_fp32_format_converter_unit: PASSED **");
    end else begin
      $display("** to_fp32_format_converter_unit: FAILED **");
    end
    $finish;
  end
endmodule
